// ===== rtl/krt_pkg.sv =====
// Package: shared types and constants of the keyed rate tracker.
`default_nettype none
package krt_pkg;
  localparam int KEY_W   = 64;
  localparam int LEVEL_W = 32;
  localparam int TIME_W  = 32;
  localparam int RATE_W  = 43;
  localparam int DROP_W  = 50;  // 32-bit drop times 256000 fits in 50 bits

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_FORGET = 1'b1;

  localparam logic [1:0] REG_MIN_INTERVAL = 2'd0;
  localparam logic [1:0] REG_STALE_AFTER  = 2'd1;
  localparam logic [1:0] REG_SWEEP_PERIOD = 2'd2;

  localparam logic [17:0] DROP_SCALE = 18'd256000;

  typedef struct packed {
    logic              command;
    logic [KEY_W-1:0]  key;
    logic [LEVEL_W-1:0] level;
    logic [TIME_W-1:0] time_ms;
  } req_t;

  typedef struct packed {
    logic [RATE_W-1:0] rate;
    logic              was_known;
    logic              table_full;
  } rsp_t;

  // Divider handshake between sequencer and divider
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;
endpackage
`default_nettype wire

// ===== rtl/krt_if.sv =====
// Interfaces: valid/ready channels for requests and results.
`default_nettype none
interface krt_req_if;
  logic valid;
  logic ready;
  krt_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface krt_rsp_if;
  logic valid;
  logic ready;
  krt_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/krt_ram.sv =====
// Generic single-port RAM with registered read.
`default_nettype none
module krt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ===== rtl/krt_div.sv =====
// Restoring divider: one quotient bit per cycle, saturated to rate width.
`default_nettype none
module krt_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire krt_pkg::div_ctl_t          ctl,
  input  wire logic [krt_pkg::DROP_W-1:0] dividend,
  input  wire logic [krt_pkg::TIME_W-1:0] divisor,
  output krt_pkg::div_sts_t               sts,
  output logic      [krt_pkg::RATE_W-1:0] quotient
);
  localparam int DW = krt_pkg::DROP_W;
  localparam int TW = krt_pkg::TIME_W;
  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] quo;
  logic [TW:0]   rem;
  logic [TW-1:0] dsr;
  logic [CW-1:0] count;
  logic          busy;
  logic          done;
  logic [TW:0]   trial;
  logic [TW:0]   diff;

  // one shift-subtract step
  always_comb begin
    trial = {rem[TW-1:0], quo[DW-1]};
    diff  = trial - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy  <= 1'b1;
        count <= CW'(DW);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      if (!diff[TW]) begin
        rem <= diff;
        quo <= {quo[DW-2:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[DW-2:0], 1'b0};
      end
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;
  assign quotient = (|quo[DW-1:krt_pkg::RATE_W]) ? {krt_pkg::RATE_W{1'b1}}
                                                 : quo[krt_pkg::RATE_W-1:0];
endmodule
`default_nettype wire

// ===== rtl/keyed_rate_tracker_ema_core.sv =====
// Top level: keyed decline-rate tracker with sequencer, entry RAM and divider.
//
//  channel | dir | payload
//  req     | in  | command, key, level, time_ms
//  rsp     | out | rate, was_known, table_full
//  cfg     | in  | cfg_we, cfg_index, cfg_data
//
// A request runs a sweep over all slots when one is due for a sample, then a
// find scan that stops at the first match, and for a rate update an issue
// state, 50 divide steps and a done state; the entry scans read and then check
// one slot at a time through a single RAM port, and the divider is bit-serial.
// Reset clears the valid bits at once, no clearing pass.
// ready is low from acceptance until the result has been taken.
`default_nettype none
module keyed_rate_tracker_ema_core #(
  parameter int ENTRIES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  krt_req_if.sink          req,
  krt_rsp_if.source        rsp,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  localparam int AW = $clog2(ENTRIES);
  localparam int CW = AW + 1;
  localparam int RW = krt_pkg::RATE_W;
  localparam int EW = krt_pkg::KEY_W + krt_pkg::LEVEL_W + krt_pkg::TIME_W + RW;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SW_RD  = 4'd1;
  localparam logic [3:0] S_SW_CHK = 4'd2;
  localparam logic [3:0] S_FD_RD  = 4'd3;
  localparam logic [3:0] S_FD_CHK = 4'd4;
  localparam logic [3:0] S_MUL    = 4'd5;
  localparam logic [3:0] S_DIV    = 4'd6;
  localparam logic [3:0] S_WAIT   = 4'd7;
  localparam logic [3:0] S_RESP   = 4'd8;

  logic [3:0] state;
  logic [15:0] min_interval;
  logic [31:0] stale_after;
  logic [31:0] sweep_period;
  logic [31:0] next_sweep;
  logic [ENTRIES-1:0] valid;
  krt_pkg::req_t cur;
  krt_pkg::rsp_t res;
  logic [CW-1:0] idx;
  logic [AW-1:0] hit_slot;

  // entry RAM
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [EW-1:0] ram_wdata;
  logic [EW-1:0] ram_rdata;
  logic [krt_pkg::KEY_W-1:0]   e_key;
  logic [krt_pkg::LEVEL_W-1:0] e_level;
  logic [krt_pkg::TIME_W-1:0]  e_time;
  logic [RW-1:0]               e_rate;

  krt_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );
  assign {e_key, e_level, e_time, e_rate} = ram_rdata;

  // lowest free slot
  logic [AW-1:0] free_slot;
  logic          any_free;
  always_comb begin
    free_slot = '0;
    any_free  = 1'b0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_slot = AW'(i);
        any_free  = 1'b1;
      end
    end
  end

  // elapsed time of the entry just read
  logic [31:0] dt;
  logic [31:0] dt_div;
  assign dt     = cur.time_ms - e_time;
  assign dt_div = (dt == '0) ? 32'd1 : dt;

  // divider
  krt_pkg::div_ctl_t div_ctl;
  krt_pkg::div_sts_t div_sts;
  logic [krt_pkg::DROP_W-1:0] dividend;
  logic [31:0] divisor;
  logic [RW-1:0] quotient;
  logic [31:0] drop;

  krt_div u_div (
    .clk(clk), .rst(rst), .ctl(div_ctl), .dividend(dividend),
    .divisor(divisor), .sts(div_sts), .quotient(quotient)
  );

  logic [AW-1:0] idx_a;
  logic          scan_last;
  logic [RW:0]   rate_sum;
  assign idx_a     = idx[AW-1:0];
  assign scan_last = (idx == CW'(ENTRIES - 1));
  assign rate_sum  = {1'b0, e_rate} + {1'b0, quotient};

  // RAM addressing and writes
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = idx_a;
    ram_wdata = {cur.key, cur.level, cur.time_ms, e_rate};
    div_ctl.start = (state == S_MUL);
    if (state == S_FD_CHK && idx == CW'(ENTRIES) && !cur.command && any_free) begin
      ram_we    = 1'b1;
      ram_addr  = free_slot;
      ram_wdata = {cur.key, cur.level, cur.time_ms, {RW{1'b0}}};
    end else if (state == S_WAIT && div_sts.done) begin
      ram_we    = 1'b1;
      ram_addr  = hit_slot;
      ram_wdata = {cur.key, cur.level, cur.time_ms, rate_sum[RW:1]};
    end else if (state == S_DIV || state == S_WAIT || state == S_MUL) begin
      ram_addr  = hit_slot;
    end
  end

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = (state == S_RESP);
  assign rsp.data  = res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_interval <= 16'd200;
      stale_after  <= 32'd300000;
      sweep_period <= 32'd60000;
    end else if (cfg_we) begin
      case (cfg_index)
        krt_pkg::REG_MIN_INTERVAL: min_interval <= cfg_data[15:0];
        krt_pkg::REG_STALE_AFTER:  stale_after  <= cfg_data;
        krt_pkg::REG_SWEEP_PERIOD: sweep_period <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      valid      <= '0;
      next_sweep <= '0;
      idx        <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            cur <= req.data;
            res <= '0;
            idx <= '0;
            if (req.data.command == krt_pkg::CMD_SAMPLE &&
                req.data.time_ms >= next_sweep) begin
              next_sweep <= req.data.time_ms + sweep_period;
              state      <= S_SW_RD;
            end else begin
              state <= S_FD_RD;
            end
          end
        end
        S_SW_RD: state <= S_SW_CHK;
        S_SW_CHK: begin
          if (valid[idx_a] && dt > stale_after) begin
            valid[idx_a] <= 1'b0;
          end
          if (scan_last) begin
            idx   <= '0;
            state <= S_FD_RD;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_SW_RD;
          end
        end
        S_FD_RD: begin
          if (idx == CW'(ENTRIES)) begin
            state <= S_FD_CHK;
          end else begin
            state <= S_FD_CHK;
          end
        end
        S_FD_CHK: begin
          if (idx == CW'(ENTRIES)) begin
            // no match
            if (cur.command == krt_pkg::CMD_SAMPLE) begin
              if (any_free) begin
                valid[free_slot] <= 1'b1;
              end else begin
                res.table_full <= 1'b1;
              end
            end
            state <= S_RESP;
          end else if (valid[idx_a] && e_key == cur.key) begin
            hit_slot      <= idx_a;
            res.was_known <= 1'b1;
            if (cur.command == krt_pkg::CMD_FORGET) begin
              valid[idx_a] <= 1'b0;
              state        <= S_RESP;
            end else if (dt < {16'd0, min_interval}) begin
              res.rate <= e_rate;
              state    <= S_RESP;
            end else begin
              drop    <= (cur.level < e_level) ? e_level - cur.level : 32'd0;
              divisor <= dt_div;
              state   <= S_MUL;
            end
          end else begin
            idx   <= idx + 1'b1;
            state <= S_FD_RD;
          end
        end
        S_MUL: state <= S_WAIT;
        S_WAIT: begin
          if (div_sts.done) begin
            res.rate <= rate_sum[RW:1];
            state    <= S_RESP;
          end
        end
        S_RESP: begin
          if (rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // scaled drop, taken by the divider on its start cycle
  assign dividend = {18'd0, drop} * {32'd0, krt_pkg::DROP_SCALE};

`ifndef SYNTHESIS
  a_div_only_update: assert property (@(posedge clk) disable iff (rst)
    div_sts.done |-> state == S_WAIT)
    else $error("divider finished outside update");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !req.ready)
    else $error("ready while busy");
  a_full_not_known: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.data.table_full && rsp.data.was_known))
    else $error("full and known together");
`endif
endmodule
`default_nettype wire
